// File: sv/amap_pkg.sv
// Shared types and constants for the arcade input mapper.
`default_nettype none
package amap_pkg;

  localparam int KEY_CODES = 128;
  localparam int KEY_IDX_W = $clog2(KEY_CODES);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_COIN_PULSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_REPEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PULSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_HOLD   = 2'd3;

  localparam logic [3:0] COIN_PULSE_RST  = 4'd12;
  localparam logic [5:0] COIN_REPEAT_RST = 6'd30;
  localparam logic [5:0] START_PULSE_RST = 6'd60;
  localparam logic [6:0] EXIT_HOLD_RST   = 7'd60;

  localparam logic       OP_KEY   = 1'b0;
  localparam logic       OP_FRAME = 1'b1;

  localparam logic [KEY_IDX_W-1:0] SC_ONE    = 7'h01;
  localparam logic [KEY_IDX_W-1:0] SC_FIVE   = 7'h05;
  localparam logic [KEY_IDX_W-1:0] SC_QUIT   = 7'h10;
  localparam logic [KEY_IDX_W-1:0] SC_PAUSE  = 7'h19;
  localparam logic [KEY_IDX_W-1:0] SC_SPACE  = 7'h40;
  localparam logic [KEY_IDX_W-1:0] SC_BKSP   = 7'h41;
  localparam logic [KEY_IDX_W-1:0] SC_PADENT = 7'h43;
  localparam logic [KEY_IDX_W-1:0] SC_ENTER  = 7'h44;
  localparam logic [KEY_IDX_W-1:0] SC_ESCAPE = 7'h45;
  localparam logic [KEY_IDX_W-1:0] SC_UP     = 7'h4C;
  localparam logic [KEY_IDX_W-1:0] SC_DOWN   = 7'h4D;
  localparam logic [KEY_IDX_W-1:0] SC_RIGHT  = 7'h4E;
  localparam logic [KEY_IDX_W-1:0] SC_LEFT   = 7'h4F;
  localparam logic [KEY_IDX_W-1:0] SC_CTRL   = 7'h63;
  localparam logic [KEY_IDX_W-1:0] SC_ALT    = 7'h64;

  localparam logic [7:0] PAD_BLUE   = 8'h80;
  localparam logic [7:0] PAD_RED    = 8'h40;
  localparam logic [7:0] PAD_YELLOW = 8'h20;
  localparam logic [7:0] PAD_GREEN  = 8'h10;
  localparam logic [7:0] PAD_SHOULD = 8'h0C;
  localparam logic [7:0] PAD_PLAY   = 8'h02;
  localparam logic [7:0] PAD_FACE   = PAD_BLUE | PAD_RED | PAD_YELLOW | PAD_GREEN;

  localparam logic [6:0] HOLD_MAX = 7'h7F;

  typedef struct packed {
    logic [3:0] coin_pulse_frames;
    logic [5:0] coin_repeat_frames;
    logic [5:0] start_pulse_frames;
    logic [6:0] exit_hold_frames;
  } amap_cfg_t;

  typedef struct packed {
    logic pause;
    logic quit;
    logic right;
    logic left;
    logic down;
    logic up;
    logic shoot;
    logic loop;
    logic coin;
    logic start;
  } amap_keys_t;

  typedef struct packed {
    logic [7:0] system_port;
    logic [7:0] player_port;
    logic       pause_pulse;
    logic       exit_flag;
  } amap_result_t;

endpackage
`default_nettype wire

// File: sv/amap_if.sv
// Request and result channel interfaces.
`default_nettype none
interface amap_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  raw_key;
  logic [15:0] joy_word;
  logic        fire_one_level;
  logic        fire_two_level;
  logic [7:0]  pad_buttons;

  modport source (output valid, opcode, raw_key, joy_word, fire_one_level,
                  fire_two_level, pad_buttons, input ready);
  modport sink (input valid, opcode, raw_key, joy_word, fire_one_level,
                fire_two_level, pad_buttons, output ready);
endinterface

interface amap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] system_port;
  logic [7:0] player_port;
  logic       pause_pulse;
  logic       exit_flag;

  modport source (output valid, system_port, player_port, pause_pulse, exit_flag,
                  input ready);
  modport sink (input valid, system_port, player_port, pause_pulse, exit_flag,
                output ready);
endinterface
`default_nettype wire

// File: sv/amap_keymap.sv
// Key-down map: decodes raw key bytes and exposes the keys the frame logic uses.
`default_nettype none
module amap_keymap (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [7:0]          raw_key,
  output amap_pkg::amap_keys_t     keys
);
  import amap_pkg::*;

  logic [KEY_CODES-1:0] key_map;
  logic [7:0]           code;

  // rotate right one bit, then invert
  assign code = ~{raw_key[0], raw_key[7:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_map <= '0;
    end else if (wr_en) begin
      key_map[code[KEY_IDX_W-1:0]] <= ~code[7];
    end
  end

  always_comb begin
    keys.pause = key_map[SC_PAUSE];
    keys.quit  = key_map[SC_QUIT];
    keys.right = key_map[SC_RIGHT];
    keys.left  = key_map[SC_LEFT];
    keys.down  = key_map[SC_DOWN];
    keys.up    = key_map[SC_UP];
    keys.shoot = key_map[SC_CTRL] | key_map[SC_SPACE];
    keys.loop  = key_map[SC_ALT];
    keys.coin  = key_map[SC_FIVE] | key_map[SC_ESCAPE] | key_map[SC_BKSP];
    keys.start = key_map[SC_ONE] | key_map[SC_ENTER] | key_map[SC_PADENT];
  end
endmodule
`default_nettype wire

// File: sv/amap_frame.sv
// Frame logic: port merge, coin/start timers, pause edge and exit request.
`default_nettype none
module amap_frame (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire amap_pkg::amap_cfg_t   cfg,
  input  wire amap_pkg::amap_keys_t  keys,
  input  wire logic [15:0]           joy_word,
  input  wire logic                  fire_one_level,
  input  wire logic                  fire_two_level,
  input  wire logic [7:0]            pad_buttons,
  output amap_pkg::amap_result_t     result
);
  import amap_pkg::*;

  logic       pause_prev;
  logic [6:0] exit_hold_count;
  logic       exit_sticky;
  logic       coin_prev;
  logic [3:0] coin_pulse_count;
  logic [5:0] coin_repeat_count;
  logic [5:0] start_pulse_count;

  logic       pause_prev_next;
  logic [6:0] exit_hold_count_next;
  logic       exit_sticky_next;
  logic [3:0] coin_pulse_count_next;
  logic [5:0] coin_repeat_count_next;
  logic [5:0] start_pulse_count_next;

  logic       pause_hit, combo, coin_held, start_held, coin_load;
  logic       right, left, down, up, shoot, loop;
  logic [6:0] hold_inc;
  logic [3:0] coin_cur;
  logic [5:0] start_cur;

  always_comb begin
    pause_hit = keys.pause | ((pad_buttons & (PAD_YELLOW | PAD_GREEN)) ==
                              (PAD_YELLOW | PAD_GREEN));
    combo     = (pad_buttons & PAD_FACE) == PAD_FACE;

    hold_inc  = (exit_hold_count < HOLD_MAX) ? exit_hold_count + 7'd1 : exit_hold_count;
    exit_hold_count_next = combo ? hold_inc : '0;
    exit_sticky_next = exit_sticky | keys.quit |
                       (combo & (hold_inc >= cfg.exit_hold_frames));
    pause_prev_next = pause_hit;

    right = joy_word[1] | keys.right;
    left  = joy_word[9] | keys.left;
    down  = (joy_word[1] ^ joy_word[0]) | keys.down;
    up    = (joy_word[9] ^ joy_word[8]) | keys.up;
    shoot = ~fire_one_level | ((pad_buttons & (PAD_BLUE | PAD_RED)) != '0) | keys.shoot;
    loop  = ~fire_two_level | ((pad_buttons & (PAD_YELLOW | PAD_GREEN)) != '0) | keys.loop;

    coin_held  = ((pad_buttons & PAD_SHOULD) != '0) | keys.coin;
    start_held = ((pad_buttons & PAD_PLAY) != '0) | keys.start;

    coin_load = coin_held & (~coin_prev | (coin_repeat_count == '0));
    if (!coin_held) begin
      coin_repeat_count_next = '0;
    end else if (coin_load) begin
      coin_repeat_count_next = cfg.coin_repeat_frames;
    end else begin
      coin_repeat_count_next = coin_repeat_count - 6'd1;
    end
    coin_cur  = coin_load ? cfg.coin_pulse_frames : coin_pulse_count;
    start_cur = start_held ? cfg.start_pulse_frames : start_pulse_count;
    coin_pulse_count_next  = (coin_cur != '0) ? coin_cur - 4'd1 : '0;
    start_pulse_count_next = (start_cur != '0) ? start_cur - 6'd1 : '0;

    result.system_port = {(coin_cur == '0), 6'h3F, (start_cur == '0)};
    result.player_port = {2'b11, ~loop, ~shoot, ~up, ~down, ~left, ~right};
    result.pause_pulse = pause_hit & ~pause_prev;
    result.exit_flag   = exit_sticky_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_prev        <= 1'b0;
      exit_hold_count   <= '0;
      exit_sticky       <= 1'b0;
      coin_prev         <= 1'b0;
      coin_pulse_count  <= '0;
      coin_repeat_count <= '0;
      start_pulse_count <= '0;
    end else if (en) begin
      pause_prev        <= pause_prev_next;
      exit_hold_count   <= exit_hold_count_next;
      exit_sticky       <= exit_sticky_next;
      coin_prev         <= coin_held;
      coin_pulse_count  <= coin_pulse_count_next;
      coin_repeat_count <= coin_repeat_count_next;
      start_pulse_count <= start_pulse_count_next;
    end
  end
endmodule
`default_nettype wire

// File: sv/arcade_input_mapper.sv
// Top level: request register, key map, frame logic and result register.
//
//  channel  | dir | handshake   | contents
//  in_ch    | in  | valid/ready | opcode, raw_key, joy_word, fire levels, pad_buttons
//  out_ch   | out | valid/ready | system_port, player_port, pause_pulse, exit_flag
//  cfg      | in  | cfg_we      | cfg_index, cfg_data
//
// One request per cycle while no result stalls; a frame request's result goes through
// the request register and then the result register; a key request gives none. The
// request and result registers each hold one entry, so a stalled result blocks at
// most one more request. Reset clears the key map, timers and both registers.
`default_nettype none
module arcade_input_mapper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  amap_in_if.sink                              in_ch,
  amap_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [amap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [amap_pkg::CFG_DATA_W-1:0] cfg_data
);
  import amap_pkg::*;

  amap_cfg_t    cfg;
  amap_keys_t   keys;
  amap_result_t res;
  amap_result_t out_q;

  logic        req_valid;
  logic        req_opcode;
  logic [7:0]  req_raw_key;
  logic [15:0] req_joy_word;
  logic        req_fire_one;
  logic        req_fire_two;
  logic [7:0]  req_pad;
  logic        out_valid;
  logic        proc;

  assign proc = req_valid & ((req_opcode == OP_KEY) | ~out_valid | out_ch.ready);
  assign in_ch.ready = ~req_valid | proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coin_pulse_frames  <= COIN_PULSE_RST;
      cfg.coin_repeat_frames <= COIN_REPEAT_RST;
      cfg.start_pulse_frames <= START_PULSE_RST;
      cfg.exit_hold_frames   <= EXIT_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COIN_PULSE:  cfg.coin_pulse_frames  <= cfg_data[3:0];
        CFG_COIN_REPEAT: cfg.coin_repeat_frames <= cfg_data[5:0];
        CFG_START_PULSE: cfg.start_pulse_frames <= cfg_data[5:0];
        CFG_EXIT_HOLD:   cfg.exit_hold_frames   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_opcode   <= in_ch.opcode;
      req_raw_key  <= in_ch.raw_key;
      req_joy_word <= in_ch.joy_word;
      req_fire_one <= in_ch.fire_one_level;
      req_fire_two <= in_ch.fire_two_level;
      req_pad      <= in_ch.pad_buttons;
    end
  end

  amap_keymap u_keymap (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (proc && req_opcode == OP_KEY),
    .raw_key (req_raw_key),
    .keys    (keys)
  );

  amap_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .en             (proc && req_opcode == OP_FRAME),
    .cfg            (cfg),
    .keys           (keys),
    .joy_word       (req_joy_word),
    .fire_one_level (req_fire_one),
    .fire_two_level (req_fire_two),
    .pad_buttons    (req_pad),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && req_opcode == OP_FRAME) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && req_opcode == OP_FRAME) begin
      out_q <= res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.system_port = out_q.system_port;
  assign out_ch.player_port = out_q.player_port;
  assign out_ch.pause_pulse = out_q.pause_pulse;
  assign out_ch.exit_flag   = out_q.exit_flag;
endmodule
`default_nettype wire

// File: sv/amap_checker.sv
// Port-level checker for the arcade input mapper, bound to the top level.
`default_nettype none
module amap_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_opcode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] system_port,
  input wire logic [7:0] player_port,
  input wire logic       exit_flag
);
  import amap_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_fixed_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (player_port[7:6] == 2'b11 && system_port[6:1] == 6'h3F))
    else $error("unused port bits not high");

  a_result_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_opcode == OP_FRAME, 2))
    else $error("result without a frame request");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(system_port) &&
    $stable(player_port) && $stable(exit_flag))
    else $error("stalled result changed");
endmodule

bind arcade_input_mapper amap_checker u_amap_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_opcode   (in_ch.opcode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .system_port (out_ch.system_port),
  .player_port (out_ch.player_port),
  .exit_flag   (out_ch.exit_flag)
);
`default_nettype wire
